// ===== rtl/core/sliding_window_average_macros.svh =====
// Assertion macros shared by the sliding window average checkers.
// Each macro samples on clk_i; the reset-gated form also uses rst_ni.
`ifndef SLIDING_WINDOW_AVERAGE_MACROS_SVH
`define SLIDING_WINDOW_AVERAGE_MACROS_SVH

// Check a property outside of reset
`define SWA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property at every edge, reset included
`define SWA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/core/swa_pkg.sv =====
// Shared constants, state types and width helpers of the sliding window average.
// No dependencies; used by every module of the block but swa_ram.
package swa_pkg;

  // Default parameter values
  localparam int unsigned MAX_WINDOW_DEF  = 128;
  localparam int unsigned SAMPLE_BITS_DEF = 16;

  // Window length register
  localparam int unsigned     WL_BITS  = 8;
  localparam logic [WL_BITS-1:0] WL_RESET = 8'd4;

  // Entries of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_MERGE,
    FS_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    DS_IDLE,
    DS_RUN,
    DS_DONE
  } div_state_e;

  // Largest window the register and the delay line allow together
  function automatic int unsigned max_k(input int unsigned max_window);
    int unsigned lim;
    lim = (1 << WL_BITS) - 1;
    return (max_window > lim) ? lim : max_window;
  endfunction

  // Width of the exact running sum
  function automatic int unsigned sum_bits(input int unsigned sample_bits,
                                           input int unsigned max_window);
    return sample_bits + $clog2(max_k(max_window));
  endfunction

endpackage

// ===== rtl/core/sliding_window_average.sv =====
// Moving average over the last window_length unsigned fractional samples.
// Top level; uses swa_pkg, swa_front, swa_queue, swa_divider.
//
// Samples enter on the in_ channel; each one that completes or advances a full
// window gives one average (sum of the last k samples divided by k, truncated),
// none is given while the window fills. in_restart_i starts a new window with
// its sample, and a write of window_length (0 acts as 1, values above
// MAX_WINDOW act as MAX_WINDOW) also empties the window. As the window fills,
// the front end adds each sample as it takes it; the sample that completes the
// window is then handed off, and once the window is full each sample goes
// through a delay-line read, an update and a hand-off, which waits while the
// queue is full. A divider producing one quotient bit per cycle sets the
// sustained rate; it takes a new sum only after handing the last average to
// its output register. A two-entry queue and the output register let samples
// keep arriving while a result waits.
module sliding_window_average #(
  parameter int unsigned MAX_WINDOW  = swa_pkg::MAX_WINDOW_DEF,
  parameter int unsigned SAMPLE_BITS = swa_pkg::SAMPLE_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [swa_pkg::WL_BITS-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [SAMPLE_BITS-1:0]      in_sample_i,
  input  logic                        in_restart_i,
  output logic                        out_valid_o,
  output logic [SAMPLE_BITS-1:0]      out_average_o,
  input  logic                        out_stall_i
);

  localparam int unsigned KW = swa_pkg::WL_BITS;
  localparam int unsigned SW = swa_pkg::sum_bits(SAMPLE_BITS, MAX_WINDOW);

  logic          push_valid;
  logic [SW-1:0] push_sum;
  logic [KW-1:0] push_k;
  logic          push_stall;
  logic          pop_valid;
  logic [SW+KW-1:0] pop_data;
  logic          pop_stall;

  swa_front #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_sample_i  (in_sample_i),
    .in_restart_i (in_restart_i),
    .push_valid_o (push_valid),
    .push_sum_o   (push_sum),
    .push_k_o     (push_k),
    .push_stall_i (push_stall)
  );

  swa_queue #(
    .WIDTH (SW + KW)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_data_i  ({push_sum, push_k}),
    .push_stall_o (push_stall),
    .pop_valid_o  (pop_valid),
    .pop_data_o   (pop_data),
    .pop_stall_i  (pop_stall)
  );

  swa_divider #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_divider (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (pop_valid),
    .in_sum_i      (pop_data[SW+KW-1:KW]),
    .in_k_i        (pop_data[KW-1:0]),
    .in_stall_o    (pop_stall),
    .out_valid_o   (out_valid_o),
    .out_average_o (out_average_o),
    .out_stall_i   (out_stall_i)
  );

endmodule

// ===== rtl/core/swa_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module swa_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 128,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/swa_front.sv =====
// Front end: accepts samples, keeps the delay line, fill count and running sum,
// and hands (sum, window) of each full window to the queue. Uses swa_pkg, swa_ram.
module swa_front #(
  parameter int unsigned MAX_WINDOW  = swa_pkg::MAX_WINDOW_DEF,
  parameter int unsigned SAMPLE_BITS = swa_pkg::SAMPLE_BITS_DEF,
  localparam int unsigned KW = swa_pkg::WL_BITS,
  localparam int unsigned SW = swa_pkg::sum_bits(SAMPLE_BITS, MAX_WINDOW)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [KW-1:0]          cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [SAMPLE_BITS-1:0] in_sample_i,
  input  logic                   in_restart_i,
  output logic                   push_valid_o,
  output logic [SW-1:0]          push_sum_o,
  output logic [KW-1:0]          push_k_o,
  input  logic                   push_stall_i
);

  localparam int unsigned AW      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned MAX_K   = swa_pkg::max_k(MAX_WINDOW);
  localparam int unsigned FW      = $clog2(MAX_K + 1);
  localparam logic [KW-1:0] MaxK  = KW'(MAX_K);
  localparam logic [AW:0]   Depth = (AW + 1)'(MAX_WINDOW);
  localparam logic [AW-1:0] PtrLast = AW'(MAX_WINDOW - 1);

  swa_pkg::front_state_e state_q, state_d;
  logic [KW-1:0]          wl_q, wl_d;
  logic [SW-1:0]          sum_q, sum_d;
  logic [FW-1:0]          fill_q, fill_d;
  logic [AW-1:0]          wp_q, wp_d;
  logic [SAMPLE_BITS-1:0] x_q, x_d;

  logic [KW-1:0]          k;
  logic                   accept;
  logic [FW-1:0]          fill_eff;
  logic [FW-1:0]          fill_inc;
  logic [SW-1:0]          sum_eff;
  logic [AW:0]            old_wide;
  logic [AW-1:0]          old_idx;
  logic [AW-1:0]          wp_next;
  logic                   ram_we;
  logic [SAMPLE_BITS-1:0] ram_wdata;
  logic                   ram_re;
  logic [SAMPLE_BITS-1:0] ram_rdata;

  // Clamp the window length to 1..MAX_K
  always_comb begin
    if (wl_q == '0) begin
      k = KW'(1);
    end else if (wl_q > MaxK) begin
      k = MaxK;
    end else begin
      k = wl_q;
    end
  end

  assign in_stall_o = (state_q != swa_pkg::FS_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // A restart drops the window before the sample is taken
  assign fill_eff = in_restart_i ? '0 : fill_q;
  assign sum_eff  = in_restart_i ? '0 : sum_q;
  assign fill_inc = fill_eff + FW'(1);

  // Slot of the sample that leaves the window, modulo the delay line depth
  always_comb begin
    old_wide = {1'b0, wp_q} + Depth - (AW + 1)'(k);
    if (old_wide >= Depth) begin
      old_wide = old_wide - Depth;
    end
    old_idx = old_wide[AW-1:0];
  end

  assign wp_next = (wp_q == PtrLast) ? '0 : wp_q + AW'(1);

  // Next state and datapath
  always_comb begin
    state_d      = state_q;
    wl_d         = wl_q;
    sum_d        = sum_q;
    fill_d       = fill_q;
    wp_d         = wp_q;
    x_d          = x_q;
    ram_we       = 1'b0;
    ram_wdata    = x_q;
    ram_re       = 1'b0;
    push_valid_o = 1'b0;
    case (state_q)
      swa_pkg::FS_IDLE: begin
        if (accept) begin
          x_d = in_sample_i;
          if (KW'(fill_eff) < k) begin
            // Window still filling: add the sample
            sum_d     = sum_eff + SW'(in_sample_i);
            fill_d    = fill_inc;
            ram_we    = 1'b1;
            ram_wdata = in_sample_i;
            wp_d      = wp_next;
            state_d   = (KW'(fill_inc) == k) ? swa_pkg::FS_PUSH : swa_pkg::FS_IDLE;
          end else begin
            // Window full: fetch the oldest sample first
            sum_d   = sum_eff;
            fill_d  = fill_eff;
            ram_re  = 1'b1;
            state_d = swa_pkg::FS_MERGE;
          end
        end
      end
      swa_pkg::FS_MERGE: begin
        // Add the new sample, drop the oldest, then store the new one at the write pointer
        sum_d     = sum_q + SW'(x_q) - SW'(ram_rdata);
        ram_we    = 1'b1;
        ram_wdata = x_q;
        wp_d      = wp_next;
        state_d   = swa_pkg::FS_PUSH;
      end
      swa_pkg::FS_PUSH: begin
        push_valid_o = 1'b1;
        if (!push_stall_i) begin
          state_d = swa_pkg::FS_IDLE;
        end
      end
      default: begin
        state_d = swa_pkg::FS_IDLE;
      end
    endcase
    // A window length write restarts the fill
    if (cfg_we_i) begin
      wl_d   = cfg_wdata_i;
      fill_d = '0;
      sum_d  = '0;
    end
  end

  assign push_sum_o = sum_q;
  assign push_k_o   = k;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= swa_pkg::FS_IDLE;
      wl_q    <= swa_pkg::WL_RESET;
      sum_q   <= '0;
      fill_q  <= '0;
      wp_q    <= '0;
    end else begin
      state_q <= state_d;
      wl_q    <= wl_d;
      sum_q   <= sum_d;
      fill_q  <= fill_d;
      wp_q    <= wp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
  end

  // Delay line of the last samples
  swa_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WINDOW)
  ) u_delay_line (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (old_idx),
    .rdata_o (ram_rdata)
  );

endmodule

// ===== rtl/core/swa_queue.sv =====
// Short FIFO of pending (sum, window) pairs between front and divider.
// Uses swa_pkg for its depth.
module swa_queue #(
  parameter int unsigned WIDTH = 31
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             push_stall_o,
  output logic             pop_valid_o,
  output logic [WIDTH-1:0] pop_data_o,
  input  logic             pop_stall_i
);

  localparam int unsigned DEPTH = swa_pkg::QUEUE_DEPTH;
  localparam int unsigned PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PtrLast = PW'(DEPTH - 1);
  localparam logic [CW-1:0] Full    = CW'(DEPTH);

  logic [WIDTH-1:0] entry_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             push;
  logic             pop;

  assign push_stall_o = (cnt_q == Full);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i && !push_stall_o;
  assign pop          = pop_valid_o && !pop_stall_i;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/core/swa_divider.sv =====
// Back end: restoring divider, one quotient bit per cycle, with output register.
// Uses swa_pkg.
module swa_divider #(
  parameter int unsigned MAX_WINDOW  = swa_pkg::MAX_WINDOW_DEF,
  parameter int unsigned SAMPLE_BITS = swa_pkg::SAMPLE_BITS_DEF,
  localparam int unsigned KW = swa_pkg::WL_BITS,
  localparam int unsigned SW = swa_pkg::sum_bits(SAMPLE_BITS, MAX_WINDOW)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic [SW-1:0]          in_sum_i,
  input  logic [KW-1:0]          in_k_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  output logic [SAMPLE_BITS-1:0] out_average_o,
  input  logic                   out_stall_i
);

  localparam int unsigned CW = $clog2(SW);
  localparam logic [CW-1:0] LastStep = CW'(SW - 1);

  swa_pkg::div_state_e    state_q, state_d;
  logic [SW-1:0]          quo_q, quo_d;
  logic [KW-1:0]          rem_q, rem_d;
  logic [KW-1:0]          k_q, k_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic                   out_valid_q, out_valid_d;
  logic [SAMPLE_BITS-1:0] out_avg_q, out_avg_d;
  logic [KW:0]            rem_sh;
  logic [KW:0]            rem_sub;
  logic                   ge;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign rem_sh  = {rem_q, quo_q[SW-1]};
  assign rem_sub = rem_sh - {1'b0, k_q};
  assign ge      = (rem_sh >= {1'b0, k_q});

  assign in_stall_o = (state_q != swa_pkg::DS_IDLE);

  always_comb begin
    state_d     = state_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    k_d         = k_q;
    cnt_d       = cnt_q;
    out_avg_d   = out_avg_q;
    // Drop the result once taken
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      swa_pkg::DS_IDLE: begin
        if (in_valid_i) begin
          quo_d   = in_sum_i;
          rem_d   = '0;
          k_d     = in_k_i;
          cnt_d   = LastStep;
          state_d = swa_pkg::DS_RUN;
        end
      end
      swa_pkg::DS_RUN: begin
        rem_d = ge ? rem_sub[KW-1:0] : rem_sh[KW-1:0];
        quo_d = {quo_q[SW-2:0], ge};
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == '0) begin
          state_d = swa_pkg::DS_DONE;
        end
      end
      swa_pkg::DS_DONE: begin
        // Hand over when the output register is free or being emptied
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_avg_d   = quo_q[SAMPLE_BITS-1:0];
          state_d     = swa_pkg::DS_IDLE;
        end
      end
      default: begin
        state_d = swa_pkg::DS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= swa_pkg::DS_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q     <= quo_d;
    rem_q     <= rem_d;
    k_q       <= k_d;
    cnt_q     <= cnt_d;
    out_avg_q <= out_avg_d;
  end

  assign out_valid_o   = out_valid_q;
  assign out_average_o = out_avg_q;

endmodule

// ===== rtl/core/swa_checker.sv =====
// Port-level checks of the sliding window average, bound to the top level.
// Uses sliding_window_average_macros.svh.
`include "sliding_window_average_macros.svh"

module swa_checker #(
  parameter int unsigned SAMPLE_BITS = swa_pkg::SAMPLE_BITS_DEF
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_stall_o,
  input logic                   out_valid_o,
  input logic [SAMPLE_BITS-1:0] out_average_o,
  input logic                   out_stall_i
);

  // Hold a stalled result
  `SWA_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_average_o), "stalled average changed or dropped")

  // Come out of reset empty and ready
  `SWA_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !out_valid_o && !in_stall_o, "block not idle in reset")

  // No average can be ready right after reset; a whole divide must run first
  `SWA_ASSERT_ALWAYS(a_reset_latency, $past(!rst_ni) |-> !out_valid_o, "average right after reset")

endmodule

bind sliding_window_average swa_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_swa_checker (.*);
